### design/clnw_pkg.sv
// shared types and constants for the character lcd nibble writer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package clnw_pkg;

  // request codes
  localparam logic [2:0] REQ_CHAR    = 3'd0;
  localparam logic [2:0] REQ_CMD     = 3'd1;
  localparam logic [2:0] REQ_CR      = 3'd2;
  localparam logic [2:0] REQ_LF      = 3'd3;
  localparam logic [2:0] REQ_NEWLINE = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;
  localparam logic [2:0] REQ_HOME    = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] CFG_LINE_WRAP    = 2'd2;

  // lcd command bytes
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  // reset values of the configuration registers
  localparam logic [1:0] ROW_COUNT_RST    = 2'd2;
  localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;

  // one input request
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } req_t;

  // one bus nibble
  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic       last;
  } nib_t;

  // classified job: up to three bytes, only the first may go to the data register
  typedef struct packed {
    logic [1:0]      nbytes;
    logic            rs_first;
    logic [7:0]      byte2;
    logic [7:0]      byte1;
    logic [7:0]      byte0;
  } job_t;

  // set-address command for a cursor position (0x80 + 0x40 * row + col)
  function automatic logic [7:0] set_addr(input logic row, input logic [5:0] col);
    set_addr = {1'b1, row, col};
  endfunction

endpackage

`default_nettype wire

### design/clnw_front.sv
// front end: configuration registers, cursor tracking and request classification
// depends on clnw_pkg; pushes jobs into clnw_queue
`timescale 1ns / 1ps
`default_nettype none

module clnw_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [5:0]       cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire clnw_pkg::req_t   in_data,
  output logic                  push,
  output clnw_pkg::job_t        push_job,
  input  wire logic             q_full
);
  import clnw_pkg::*;

  logic [1:0] row_count;
  logic [5:0] column_count;
  logic       line_wrap;
  logic [5:0] cursor_col;
  logic       cursor_row;
  logic [5:0] cursor_col_next;
  logic       cursor_row_next;
  logic       accept;
  logic       row_lf;
  logic [5:0] col_inc;
  logic       wrap;
  logic       known;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
      line_wrap    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count    <= cfg_data[1:0];
        CFG_COLUMN_COUNT: column_count <= cfg_data;
        CFG_LINE_WRAP:    line_wrap    <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // row after a line feed: only row 0 can move on, and only with a row count of two or more
  assign row_lf  = !cursor_row && (row_count >= 2'd2);
  assign col_inc = cursor_col + 6'd1;
  assign wrap    = line_wrap && (col_inc == column_count);

  // classify the request into bytes and the cursor update
  always_comb begin
    push_job        = '0;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    known           = 1'b1;
    unique case (in_data.req_type)
      REQ_CHAR: begin
        push_job.rs_first = 1'b1;
        push_job.byte0    = in_data.data_byte;
        push_job.byte1    = set_addr(row_lf, col_inc);
        push_job.byte2    = set_addr(row_lf, 6'd0);
        push_job.nbytes   = wrap ? 2'd3 : 2'd1;
        cursor_col_next   = wrap ? 6'd0 : col_inc;
        cursor_row_next   = wrap ? row_lf : cursor_row;
      end
      REQ_CMD: begin
        push_job.byte0  = in_data.data_byte;
        push_job.nbytes = 2'd1;
      end
      REQ_CR: begin
        push_job.byte0  = set_addr(cursor_row, 6'd0);
        push_job.nbytes = 2'd1;
        cursor_col_next = 6'd0;
      end
      REQ_LF: begin
        push_job.byte0  = set_addr(row_lf, cursor_col);
        push_job.nbytes = 2'd1;
        cursor_row_next = row_lf;
      end
      REQ_NEWLINE: begin
        push_job.byte0  = set_addr(row_lf, cursor_col);
        push_job.byte1  = set_addr(row_lf, 6'd0);
        push_job.nbytes = 2'd2;
        cursor_row_next = row_lf;
        cursor_col_next = 6'd0;
      end
      REQ_CLEAR: begin
        push_job.byte0  = CMD_CLEAR;
        push_job.nbytes = 2'd1;
        cursor_col_next = 6'd0;
        cursor_row_next = 1'b0;
      end
      REQ_HOME: begin
        push_job.byte0  = CMD_HOME;
        push_job.nbytes = 2'd1;
        cursor_col_next = 6'd0;
        cursor_row_next = 1'b0;
      end
      default: known = 1'b0;
    endcase
  end

  // unused request codes are swallowed without a job
  assign push = accept && known;

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 6'd0;
      cursor_row <= 1'b0;
    end else if (accept) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

`default_nettype wire

### design/clnw_queue.sv
// two-entry job queue between the front end and the nibble sender
// depends on clnw_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module clnw_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire clnw_pkg::job_t   push_job,
  output logic                  full,
  input  wire logic             pop,
  output clnw_pkg::job_t        head,
  output logic                  empty
);
  import clnw_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/clnw_back.sv
// back end: splits queued jobs into nibbles, high nibble first, into an output register
// depends on clnw_pkg; reads the head of clnw_queue
`timescale 1ns / 1ps
`default_nettype none

module clnw_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire clnw_pkg::job_t   head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output clnw_pkg::nib_t        out_data
);
  import clnw_pkg::*;

  logic [2:0] pos;
  logic       advance;
  logic [7:0] cur_byte;
  logic       is_last;
  nib_t       nib;

  // output register may load when empty or being taken
  assign advance = !out_valid || !out_stall;

  // byte of the head job at the current position
  always_comb begin
    unique case (pos[2:1])
      2'd0:    cur_byte = head.byte0;
      2'd1:    cur_byte = head.byte1;
      default: cur_byte = head.byte2;
    endcase
  end

  assign is_last        = (pos == ({head.nbytes, 1'b0} - 3'd1));
  assign nib.nibble     = pos[0] ? cur_byte[3:0] : cur_byte[7:4];
  assign nib.reg_select = (pos[2:1] == 2'd0) && head.rs_first;
  assign nib.last       = is_last;
  assign pop            = advance && !empty && is_last;

  // nibble position within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else if (advance && !empty) begin
      pos <= is_last ? 3'd0 : pos + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      out_data <= nib;
    end
  end

endmodule

`default_nettype wire

### design/char_lcd_nibble_writer.sv
// character lcd nibble writer: request front end, job queue, nibble sender
// depends on clnw_pkg, clnw_front, clnw_queue and clnw_back
//
// Usage: a request (req_type, data_byte) enters on in_valid/in_stall and is
// taken at an edge with in_valid high and in_stall low. Each request yields
// 0, 2, 4 or 6 nibbles on out_valid/out_stall, high nibble first, each with
// reg_select; last marks the final nibble of the request.
// The front end updates the cursor and classifies the request in the cycle
// it is taken; the job then waits in a two-entry queue. With the queue empty
// the job passes through the queue entry and then the output register.
// Throughput: the sender emits one nibble a cycle while out_stall is low, with no
// gap between requests, so a request occupies the output for two nibbles per byte;
// the front end takes one request a cycle while the queue has room.
// An unused request code is taken and produces nothing.
// Configuration: cfg_write with cfg_index 0 row_count, 1 column_count,
// 2 line_wrap; write only while idle.
// Reset: synchronous rst clears cursor to column 0, row 0, empties queue and
// output, and loads row_count 2, column_count 16, line_wrap 0.
// When out_stall is high the output nibble holds; the queue fills and
// in_stall rises once both entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_writer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [5:0]       cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire clnw_pkg::req_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output clnw_pkg::nib_t        out_data
);
  import clnw_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t head;
  logic empty;

  // request classification
  clnw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  // job queue
  clnw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // nibble sender
  clnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### verif/char_lcd_nibble_writer_tb.sv
// self-checking testbench for the character lcd nibble writer
// depends on clnw_pkg and char_lcd_nibble_writer; predicts bus nibbles per request
`timescale 1ns / 1ps

module char_lcd_nibble_writer_tb;
  import clnw_pkg::*;

  localparam logic [2:0] REQ_UNUSED  = 3'd7;
  localparam logic [7:0] ADDR_BASE   = 8'h80;
  localparam logic [7:0] ROW1_OFFSET = 8'h40;
  localparam int         SETTLE      = 8;
  localparam int         QUIET_LIMIT = 4000;

  // cursor tracker and queue of nibbles the bus should carry
  class nibble_ledger;
    nib_t       due_nibbles[$];
    logic [1:0] rows;
    logic [5:0] cols;
    logic       wrap;
    logic [5:0] col;
    logic       row;
    int         failures;

    function new();
      rows     = ROW_COUNT_RST;
      cols     = COLUMN_COUNT_RST;
      wrap     = 1'b0;
      col      = '0;
      row      = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
        CFG_ROW_COUNT:    rows = val[1:0];
        CFG_COLUMN_COUNT: cols = val;
        CFG_LINE_WRAP:    wrap = val[0];
        default: ;
      endcase
    endfunction

    // a byte goes out as two nibbles, high first
    function void push_byte(logic [7:0] b, logic rs);
      nib_t n;
      n.nibble     = b[7:4];
      n.reg_select = rs;
      n.last       = 1'b0;
      due_nibbles.push_back(n);
      n.nibble     = b[3:0];
      due_nibbles.push_back(n);
    endfunction

    function void push_address();
      logic [7:0] addr;
      addr = (ADDR_BASE | (row ? ROW1_OFFSET : 8'h00)) + {2'b00, col};
      push_byte(addr, 1'b0);
    endfunction

    function void advance_row();
      int nxt;
      nxt = int'(row) + 1;
      if (nxt >= int'(rows) || nxt > 1) nxt = 0;
      row = nxt[0];
      push_address();
    endfunction

    function void return_carriage();
      col = '0;
      push_address();
    endfunction

    // predict the nibbles for one accepted request
    function void take_request(req_t r);
      int prior_size;
      prior_size = due_nibbles.size();
      case (r.req_type)
        REQ_CHAR: begin
          push_byte(r.data_byte, 1'b1);
          col = col + 6'd1;
          if (wrap && col == cols) begin
            advance_row();
            return_carriage();
          end
        end
        REQ_CMD:     push_byte(r.data_byte, 1'b0);
        REQ_CR:      return_carriage();
        REQ_LF:      advance_row();
        REQ_NEWLINE: begin
          advance_row();
          return_carriage();
        end
        REQ_CLEAR, REQ_HOME: begin
          push_byte((r.req_type == REQ_CLEAR) ? CMD_CLEAR : CMD_HOME, 1'b0);
          col = '0;
          row = 1'b0;
        end
        default: ;
      endcase
      if (due_nibbles.size() > prior_size) due_nibbles[due_nibbles.size() - 1].last = 1'b1;
    endfunction

    // compare a nibble taken from the bus with the oldest prediction
    function void match_nibble(nib_t got);
      nib_t want;
      if (due_nibbles.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected nibble %h rs %b last %b", got.nibble, got.reg_select, got.last);
        return;
      end
      want = due_nibbles.pop_front();
      if (got.nibble !== want.nibble || got.reg_select !== want.reg_select ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("nibble mismatch: expected %h rs %b last %b, got %h rs %b last %b",
                   want.nibble, want.reg_select, want.last,
                   got.nibble, got.reg_select, got.last);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  nib_t       out_nib;

  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           quiet_cycles = 0;
  nibble_ledger ledger = new();

  char_lcd_nibble_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_nib)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
  end

  // check every nibble taken from the bus
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.match_nibble(out_nib);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** char_lcd_nibble_writer: FAILED **");
      $finish;
    end
  end

  // offer one request, with random idle cycles first, and wait for it to be taken
  task automatic send_req(input logic [2:0] kind, input logic [7:0] value);
    req_t r;
    r.req_type  = kind;
    r.data_byte = value;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.take_request(r);
  endtask

  // wait for the bus to drain, then let requests that give nothing settle
  task automatic wait_idle();
    while (ledger.due_nibbles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three registers on consecutive edges
  task automatic write_config(input logic [1:0] rows, input logic [5:0] cols,
                              input logic wrap);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= {4'b0000, rows};
    @(posedge clk);
    ledger.set_reg(CFG_ROW_COUNT, {4'b0000, rows});
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= cols;
    @(posedge clk);
    ledger.set_reg(CFG_COLUMN_COUNT, cols);
    cfg_index <= CFG_LINE_WRAP;
    cfg_data  <= {5'b00000, wrap};
    @(posedge clk);
    ledger.set_reg(CFG_LINE_WRAP, {5'b00000, wrap});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // weighted request mix, mostly characters so the cursor gets far enough to wrap
  task automatic send_random(input bit chars_only);
    int         pick;
    logic [2:0] kind;
    pick = $urandom_range(99, 0);
    if (chars_only || pick < 55) kind = REQ_CHAR;
    else if (pick < 65)          kind = REQ_CMD;
    else if (pick < 71)          kind = REQ_CR;
    else if (pick < 77)          kind = REQ_LF;
    else if (pick < 83)          kind = REQ_NEWLINE;
    else if (pick < 89)          kind = REQ_CLEAR;
    else if (pick < 95)          kind = REQ_HOME;
    else                         kind = REQ_UNUSED;
    send_req(kind, 8'($urandom_range(255, 0)));
  endtask

  task automatic run_phase(input logic [1:0] rows, input logic [5:0] cols, input logic wrap,
                           input int src_pct, input int sink_pct, input int count,
                           input bit chars_only);
    wait_idle();
    write_config(rows, cols, wrap);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_random(chars_only);
    in_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_config(2'd2, 6'd16, 1'b0);

    // data extremes, every request type, unused code, row wrap on line feed
    send_req(REQ_CHAR, 8'h00);
    send_req(REQ_CHAR, 8'hFF);
    send_req(REQ_CHAR, 8'h41);
    send_req(REQ_CMD, 8'h00);
    send_req(REQ_CMD, 8'hFF);
    send_req(REQ_CR, 8'hFF);
    send_req(REQ_LF, 8'h00);
    send_req(REQ_LF, 8'h00);
    send_req(REQ_NEWLINE, 8'h00);
    send_req(REQ_CLEAR, 8'h00);
    send_req(REQ_HOME, 8'hFF);
    send_req(REQ_UNUSED, 8'hA5);
    send_req(REQ_CHAR, 8'h5A);
    in_valid <= 1'b0;

    // automatic new line on a narrow display, both rows
    wait_idle();
    write_config(2'd2, 6'd2, 1'b1);
    send_req(REQ_CHAR, 8'h31);
    send_req(REQ_CHAR, 8'h32);
    send_req(REQ_CHAR, 8'h33);
    send_req(REQ_CHAR, 8'h34);
    send_req(REQ_LF, 8'h00);
    send_req(REQ_HOME, 8'h00);
    in_valid <= 1'b0;

    // single row keeps the cursor on row 0
    wait_idle();
    write_config(2'd1, 6'd63, 1'b0);
    send_req(REQ_LF, 8'h00);
    send_req(REQ_CHAR, 8'h7E);
    in_valid <= 1'b0;

    // random phases across settings and idling patterns
    run_phase(2'd2, 6'd16, 1'b1, 0, 0, 30, 1'b0);
    run_phase(2'd1, 6'd5, 1'b1, 79, 0, 30, 1'b0);
    run_phase(2'd2, 6'd63, 1'b1, 0, 79, 70, 1'b1);
    run_phase(2'd0, 6'd1, 1'b1, 29, 29, 20, 1'b0);
    run_phase(2'd3, 6'd0, 1'b1, 29, 29, 70, 1'b1);
    run_phase(2'd2, 6'd3, 1'b0, 79, 0, 15, 1'b0);
    run_phase(2'd1, 6'd63, 1'b0, 0, 79, 15, 1'b0);

    wait_idle();
    if (ledger.failures == 0 && ledger.due_nibbles.size() == 0) begin
      $display("** char_lcd_nibble_writer: PASSED **");
    end else begin
      $display("** char_lcd_nibble_writer: FAILED **");
    end
    $finish;
  end

endmodule
